FILE: rtl/core/escaped_frame_parser_unit_assert.svh
// Assertion helpers shared by the RTL. Both sample on the rising edge of clk
// and are switched off while arst_n is low.
`ifndef ESCAPED_FRAME_PARSER_UNIT_ASSERT_SVH
`define ESCAPED_FRAME_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/efp_pkg.sv
package efp_pkg;

	// Result kinds as they appear on the output tuser.
	typedef enum logic [2:0] {
		KIND_METHOD = 3'd0,
		KIND_PARAM  = 3'd1,
		KIND_ID     = 3'd2,
		KIND_END    = 3'd3,
		KIND_ABORT  = 3'd4
	} efp_kind_t;

	// Configuration register indexes.
	localparam logic CfgStartCode  = 1'b0;
	localparam logic CfgEscapeCode = 1'b1;

	localparam logic [7:0] StartCodeReset  = 8'h7E;
	localparam logic [7:0] EscapeCodeReset = 8'h7D;

	localparam logic [7:0] EscXor  = 8'h20;
	localparam logic [7:0] SumGood = 8'hFF;

	// Frame positions: idle, expecting length, expecting method, first parameter.
	localparam logic [8:0] PosIdle      = 9'd0;
	localparam logic [8:0] PosLength    = 9'd1;
	localparam logic [8:0] PosMethod    = 9'd2;
	localparam logic [8:0] PosParamBase = 9'd3;
	// The checksum byte sits at length plus this offset.
	localparam logic [8:0] PosEndOffset = 9'd4;

	typedef struct packed {
		logic [8:0] pos;
		logic [7:0] sum;
		logic       esc;
		logic [7:0] len;
	} efp_state_t;

	typedef struct packed {
		efp_kind_t  kind;
		logic [7:0] value;
		logic [7:0] index;
		logic [7:0] len;
		logic       good;
	} efp_result_t;

endpackage

FILE: rtl/core/escaped_frame_parser_unit.sv
// Channel   Direction  Beat contents
// s_*       in         one raw received byte
// m_*       out        one decoded frame item (kind in tuser)
// cfg_*     in         one register write (index, data)
//
// One byte is accepted per cycle when the output side keeps up. A byte is held in the input
// register. It is decoded and the state updated as it leaves, and its result (if any) is offered
// from the output register from that edge on. Reset clears the parser state and the valid flags
// and restores the default start and escape codes. A stalled output only holds back bytes that
// produce a result; bytes that are dropped or absorbed keep flowing.
module escaped_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] item_value, [15:8] param_index,
	                               // [23:16] frame_length, [24] checksum_good,
	                               // [31:25] zero
	output logic [2:0]  m_tuser,   // [2:0] item_kind

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	// Input register stage.
	logic                 valid_s1;
	logic [7:0]           byte_s1;

	// Output register stage.
	logic                 valid_s2;
	efp_pkg::efp_result_t res_s2;

	// Parser state and configuration.
	efp_pkg::efp_state_t  state_q;
	logic [7:0]           start_code_q;
	logic [7:0]           escape_code_q;

	efp_pkg::efp_state_t  next_state;
	efp_pkg::efp_result_t result;
	logic                 has_result;
	logic                 adv_s1;

	efp_decode u_decode (
		.state       (state_q),
		.rx_byte     (byte_s1),
		.start_code  (start_code_q),
		.escape_code (escape_code_q),
		.next_state  (next_state),
		.has_result  (has_result),
		.result      (result)
	);

	// The held byte moves on when its result has room, or when it makes none.
	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready || !has_result);
	assign s_tready = !valid_s1 || adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q  <= efp_pkg::StartCodeReset;
			escape_code_q <= efp_pkg::EscapeCodeReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				efp_pkg::CfgStartCode:  start_code_q  <= cfg_data;
				efp_pkg::CfgEscapeCode: escape_code_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && has_result) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {7'd0, res_s2.good, res_s2.len, res_s2.index, res_s2.value};

`include "escaped_frame_parser_unit_assert.svh"

	// A byte that cannot leave the input register stays put.
	`EFP_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1,
		valid_s1 && byte_s1 == $past(byte_s1), "input stage lost a held byte")

	// The frame never runs past its checksum position.
	`EFP_ASSERT_SAME(a_pos_bound, 1'b1,
		state_q.pos <= {1'b0, state_q.len} + efp_pkg::PosEndOffset,
		"frame position beyond checksum")

	// An escape can only be pending inside a frame.
	`EFP_ASSERT_SAME(a_esc_in_frame, state_q.esc, state_q.pos != efp_pkg::PosIdle,
		"escape pending while idle")

	// Only the end item carries a good checksum flag.
	`EFP_ASSERT_SAME(a_good_on_end, valid_s2 && res_s2.good,
		res_s2.kind == efp_pkg::KIND_END, "checksum flag on a non-end item")

endmodule

FILE: rtl/core/efp_decode.sv
// Per-byte frame decoder: next parser state and the optional result for one
// raw byte. Purely combinational.
module efp_decode (
	input  efp_pkg::efp_state_t  state,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           start_code,
	input  logic [7:0]           escape_code,
	output efp_pkg::efp_state_t  next_state,
	output logic                 has_result,
	output efp_pkg::efp_result_t result
);

	logic [7:0] data;
	logic [7:0] sum_new;
	logic [8:0] end_pos;
	logic [8:0] param_off;

	assign data      = state.esc ? (rx_byte ^ efp_pkg::EscXor) : rx_byte;
	assign sum_new   = state.sum + data;
	assign end_pos   = {1'b0, state.len} + efp_pkg::PosEndOffset;
	assign param_off = state.pos - efp_pkg::PosParamBase;

	always_comb begin
		next_state   = state;
		has_result   = 1'b0;
		result.kind  = efp_pkg::KIND_ABORT;
		result.value = '0;
		result.index = '0;
		result.len   = '0;
		result.good  = 1'b0;

		priority if (state.pos == efp_pkg::PosIdle) begin
			if (rx_byte == start_code) begin
				next_state.pos = efp_pkg::PosLength;
				next_state.sum = '0;
				next_state.esc = 1'b0;
			end
		end else if (rx_byte == start_code) begin
			// A raw start byte inside a frame aborts it and opens a new one.
			next_state.pos = efp_pkg::PosLength;
			next_state.sum = '0;
			next_state.esc = 1'b0;
			has_result     = 1'b1;
		end else if (!state.esc && rx_byte == escape_code) begin
			next_state.esc = 1'b1;
		end else if (state.pos == efp_pkg::PosLength) begin
			next_state.esc = 1'b0;
			next_state.len = data;
			next_state.pos = efp_pkg::PosMethod;
		end else begin
			next_state.esc = 1'b0;
			next_state.sum = sum_new;
			has_result     = 1'b1;
			result.value   = data;
			result.len     = state.len;
			priority if (state.pos == efp_pkg::PosMethod) begin
				next_state.pos = efp_pkg::PosParamBase;
				result.kind    = efp_pkg::KIND_METHOD;
			end else if (state.pos >= end_pos) begin
				next_state.pos = efp_pkg::PosIdle;
				next_state.sum = '0;
				result.kind    = efp_pkg::KIND_END;
				result.good    = (sum_new == efp_pkg::SumGood);
			end else if (state.pos == end_pos - 9'd1) begin
				next_state.pos = state.pos + 9'd1;
				result.kind    = efp_pkg::KIND_ID;
			end else begin
				next_state.pos = state.pos + 9'd1;
				result.kind    = efp_pkg::KIND_PARAM;
				result.index   = param_off[7:0];
			end
		end
	end

endmodule

FILE: tb/sv/escaped_frame_parser_unit_test.sv
module escaped_frame_parser_unit_test;
	import efp_pkg::*;

	// How a sent byte is checked. Most bytes go through the decoder model below;
	// the opening table can also state the outcome outright.
	typedef enum logic [1:0] {
		FROM_DECODER = 2'd0,
		NO_ITEM      = 2'd1,
		TABLE_ITEM   = 2'd2
	} item_check_mode_t;

	typedef struct packed {
		logic [7:0]       rx;
		item_check_mode_t how;
		efp_result_t      res;
	} opening_row_t;

	typedef struct {
		item_check_mode_t how;
		efp_result_t      res;
	} item_check_t;

	localparam int unsigned WATCHDOG_LIMIT   = 2000;
	localparam int unsigned LONG_HOLD_CYCLES = 64;
	localparam int unsigned LONG_HOLD_AFTER  = 200;
	localparam int unsigned PHASE_BYTES      = 35;
	localparam int unsigned SETTLE_CYCLES    = 4;
	localparam int unsigned MAX_PARAMS       = 255;

	// Opening sequence, run with the reset codes (start 0x7E, escape 0x7D).
	// It walks idle bytes, an escaped frame with a good checksum, an empty frame
	// with a bad checksum, a start byte right after an escape, a start byte in
	// the method slot and an escaped length byte. The last frame is left open
	// on purpose; the first random frame aborts it.
	localparam opening_row_t OPENING_ROWS [25] = '{
		'{8'h00, NO_ITEM,      '0},
		'{8'hFF, NO_ITEM,      '0},
		'{8'h7E, NO_ITEM,      '0},
		'{8'h02, NO_ITEM,      '0},
		'{8'h10, TABLE_ITEM,   '{KIND_METHOD, 8'h10, 8'h00, 8'h02, 1'b0}},
		'{8'h7D, NO_ITEM,      '0},
		'{8'h5E, TABLE_ITEM,   '{KIND_PARAM,  8'h7E, 8'h00, 8'h02, 1'b0}},
		'{8'h7D, NO_ITEM,      '0},
		// An escape byte while an escape is pending is data.
		'{8'h7D, TABLE_ITEM,   '{KIND_PARAM,  8'h5D, 8'h01, 8'h02, 1'b0}},
		'{8'h00, TABLE_ITEM,   '{KIND_ID,     8'h00, 8'h00, 8'h02, 1'b0}},
		'{8'h14, TABLE_ITEM,   '{KIND_END,    8'h14, 8'h00, 8'h02, 1'b1}},
		'{8'h7E, NO_ITEM,      '0},
		'{8'h00, NO_ITEM,      '0},
		'{8'hFF, TABLE_ITEM,   '{KIND_METHOD, 8'hFF, 8'h00, 8'h00, 1'b0}},
		'{8'hFF, TABLE_ITEM,   '{KIND_ID,     8'hFF, 8'h00, 8'h00, 1'b0}},
		'{8'h00, TABLE_ITEM,   '{KIND_END,    8'h00, 8'h00, 8'h00, 1'b0}},
		'{8'h7E, NO_ITEM,      '0},
		'{8'h05, NO_ITEM,      '0},
		'{8'h01, FROM_DECODER, '0},
		'{8'h7D, NO_ITEM,      '0},
		'{8'h7E, TABLE_ITEM,   '{KIND_ABORT,  8'h00, 8'h00, 8'h00, 1'b0}},
		'{8'hFF, NO_ITEM,      '0},
		'{8'h7E, TABLE_ITEM,   '{KIND_ABORT,  8'h00, 8'h00, 8'h00, 1'b0}},
		'{8'h7D, NO_ITEM,      '0},
		'{8'h31, NO_ITEM,      '0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CfgStartCode;
	logic [7:0]  cfg_data  = 8'h00;

	// Decoder model state, a private copy of what the parser keeps.
	logic [8:0] dec_pos    = PosIdle;
	logic [7:0] dec_sum    = 8'h00;
	logic       dec_esc    = 1'b0;
	logic [7:0] dec_len    = 8'h00;
	logic [7:0] dec_start  = StartCodeReset;
	logic [7:0] dec_escape = EscapeCodeReset;

	// Codes the frame builder encodes with; they follow every register load.
	logic [7:0] line_start  = StartCodeReset;
	logic [7:0] line_escape = EscapeCodeReset;

	efp_result_t  pending_items [$];
	item_check_t  byte_checks [$];
	int unsigned  error_count    = 0;
	int unsigned  bytes_offered  = 0;
	int unsigned  bytes_accepted = 0;
	int unsigned  quiet_cycles   = 0;
	bit           idling         = 1'b0;
	bit           long_hold_done = 1'b0;

	escaped_frame_parser_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Decodes one raw byte against the model state. Returns 1 when the byte
	// yields a frame item, which is then placed in item.
	function automatic bit decode_rx_byte(input logic [7:0] rx, output efp_result_t item);
		logic [7:0] d;
		logic [8:0] end_pos;
		item = '0;
		if (dec_pos == PosIdle) begin
			// Only the start code leaves idle; everything else is line noise.
			if (rx == dec_start) begin
				dec_pos = PosLength;
				dec_sum = 8'h00;
				dec_esc = 1'b0;
			end
			return 1'b0;
		end
		// A raw start code always wins, even right after an escape and even
		// when the escape code has the same value.
		if (rx == dec_start) begin
			dec_pos   = PosLength;
			dec_sum   = 8'h00;
			dec_esc   = 1'b0;
			item.kind = KIND_ABORT;
			return 1'b1;
		end
		if (!dec_esc && rx == dec_escape) begin
			dec_esc = 1'b1;
			return 1'b0;
		end
		d       = dec_esc ? (rx ^ EscXor) : rx;
		dec_esc = 1'b0;
		if (dec_pos == PosLength) begin
			// The length byte is neither reported nor summed.
			dec_len = d;
			dec_pos = PosMethod;
			return 1'b0;
		end
		dec_sum    = dec_sum + d;
		item.value = d;
		item.len   = dec_len;
		if (dec_pos == PosMethod) begin
			dec_pos   = PosParamBase;
			item.kind = KIND_METHOD;
			return 1'b1;
		end
		end_pos = {1'b0, dec_len} + PosEndOffset;
		if (dec_pos >= end_pos) begin
			item.kind = KIND_END;
			item.good = (dec_sum == SumGood);
			dec_pos   = PosIdle;
			dec_sum   = 8'h00;
			return 1'b1;
		end
		if (dec_pos == end_pos - 9'd1) begin
			item.kind = KIND_ID;
		end else begin
			item.kind  = KIND_PARAM;
			item.index = 8'(dec_pos - PosParamBase);
		end
		dec_pos = dec_pos + 9'd1;
		return 1'b1;
	endfunction

	// All bookkeeping happens on the sampled handshakes of one edge. Output
	// beats are checked before the input beat of the same edge is decoded, so a
	// result can never be matched against an item that was only just sent.
	always @(posedge clk) begin : scoreboard
		efp_result_t got;
		efp_result_t want;
		efp_result_t decoded;
		item_check_t chk;
		bit          made;
		bit          busy;
		busy = 1'b0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				busy       = 1'b1;
				got.kind   = efp_kind_t'(m_tuser);
				got.value  = m_tdata[7:0];
				got.index  = m_tdata[15:8];
				got.len    = m_tdata[23:16];
				got.good   = m_tdata[24];
				if (pending_items.size() == 0) begin
					$error("unexpected item: kind %0d value %0h", got.kind, got.value);
					error_count++;
				end else begin
					want = pending_items.pop_front();
					if (got.kind !== want.kind) begin
						$error("item_kind: expected %0d, got %0d", want.kind, got.kind);
						error_count++;
					end
					if (got.value !== want.value) begin
						$error("item_value: expected %0h, got %0h", want.value, got.value);
						error_count++;
					end
					if (got.index !== want.index) begin
						$error("param_index: expected %0d, got %0d", want.index, got.index);
						error_count++;
					end
					if (got.len !== want.len) begin
						$error("frame_length: expected %0d, got %0d", want.len, got.len);
						error_count++;
					end
					if (got.good !== want.good) begin
						$error("checksum_good: expected %0d, got %0d", want.good, got.good);
						error_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				busy = 1'b1;
				bytes_accepted++;
				chk  = byte_checks.pop_front();
				made = decode_rx_byte(s_tdata, decoded);
				if (chk.how == TABLE_ITEM) begin
					pending_items.push_back(chk.res);
				end else if (chk.how == FROM_DECODER && made) begin
					pending_items.push_back(decoded);
				end
			end
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				if (cfg_index == CfgStartCode) begin
					dec_start = cfg_data;
				end else begin
					dec_escape = cfg_data;
				end
			end
			// Watchdog: a long run of edges with no beat anywhere means a hang.
			quiet_cycles = busy ? 0 : quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// Output side. Random short stalls while idling is on, plus one long
	// hold-off partway through so the parser backs up and stops taking bytes.
	initial begin : receiver
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && bytes_accepted >= LONG_HOLD_AFTER) begin
				long_hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (idling && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Offers one byte and returns at the edge where its beat is taken. The
	// byte's check rule is queued first so the scoreboard sees it in order.
	task automatic offer_byte(input logic [7:0] rx, input item_check_mode_t how,
	                          input efp_result_t res);
		item_check_t chk;
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		chk.how = how;
		chk.res = res;
		byte_checks.push_back(chk);
		s_tvalid <= 1'b1;
		s_tdata  <= rx;
		bytes_offered++;
		do @(posedge clk); while (!s_tready);
	endtask

	// Puts one decoded byte on the line, escaping it when it collides with a
	// code and now and then for no reason at all, which is legal.
	task automatic send_coded(input logic [7:0] d);
		if (d == line_start || d == line_escape || $urandom_range(0, 7) == 0) begin
			offer_byte(line_escape, FROM_DECODER, '0);
			offer_byte(d ^ EscXor, FROM_DECODER, '0);
		end else begin
			offer_byte(d, FROM_DECODER, '0);
		end
	endtask

	// Builds a frame with plen random parameters. spoil breaks the checksum;
	// a nonzero cut stops after that many frame bytes, leaving it unfinished.
	task automatic send_frame(input int unsigned plen, input bit spoil, input int unsigned cut);
		logic [7:0]  body [$];
		logic [7:0]  sum;
		logic [7:0]  d;
		int unsigned k;
		sum = 8'h00;
		body.push_back(8'(plen));
		// Method, parameters and id.
		for (k = 0; k < plen + 2; k++) begin
			d   = 8'($urandom);
			sum = sum + d;
			body.push_back(d);
		end
		d = SumGood - sum;
		if (spoil) begin
			d = d ^ 8'($urandom_range(1, 255));
		end
		body.push_back(d);
		offer_byte(line_start, FROM_DECODER, '0);
		for (k = 0; k < body.size(); k++) begin
			if (cut != 0 && k >= cut) begin
				break;
			end
			send_coded(body[k]);
		end
	endtask

	// Mostly well-formed frames with random content; the rest is bad
	// checksums, cut-off frames and noise between frames.
	task automatic random_traffic(input int unsigned budget);
		int unsigned first;
		int unsigned n;
		first = bytes_offered;
		while (bytes_offered - first < budget) begin
			case ($urandom_range(0, 9))
				0: begin
					n = $urandom_range(1, 4);
					repeat (n) offer_byte(8'($urandom), FROM_DECODER, '0);
					if ($urandom_range(0, 1) == 0) begin
						offer_byte(line_escape, FROM_DECODER, '0);
						offer_byte(8'($urandom), FROM_DECODER, '0);
					end
				end
				1: send_frame($urandom_range(0, 6), 1'b0, $urandom_range(1, 5));
				2: send_frame($urandom_range(0, 6), 1'b1, 0);
				default: begin
					n = ($urandom_range(0, 39) == 0) ? MAX_PARAMS : $urandom_range(0, 6);
					send_frame(n, 1'b0, 0);
				end
			endcase
		end
	endtask

	// Stops sending and waits until every expected item has come back, then lets
	// any byte still in the input register that makes no item drain as well.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_items.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Loads both codes back to back; valid stays high across the two beats.
	task automatic load_codes(input logic [7:0] start_code, input logic [7:0] escape_code);
		cfg_valid <= 1'b1;
		cfg_index <= CfgStartCode;
		cfg_data  <= start_code;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CfgEscapeCode;
		cfg_data  <= escape_code;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		line_start  = start_code;
		line_escape = escape_code;
	endtask

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling = 1'b1;

		// Reset codes first, so the opening table also checks the defaults.
		foreach (OPENING_ROWS[r]) begin
			offer_byte(OPENING_ROWS[r].rx, OPENING_ROWS[r].how, OPENING_ROWS[r].res);
		end
		random_traffic(PHASE_BYTES);
		settle();

		// Code extremes, both ways round.
		load_codes(8'h00, 8'hFF);
		random_traffic(PHASE_BYTES);
		settle();

		load_codes(8'hFF, 8'h00);
		send_frame(MAX_PARAMS, 1'b0, 0);
		random_traffic(10);
		settle();

		// Start equal to escape: that value always restarts the frame.
		load_codes(8'h55, 8'h55);
		random_traffic(PHASE_BYTES);
		settle();

		load_codes(8'($urandom), 8'($urandom));
		random_traffic(PHASE_BYTES);
		settle();

		// Last stretch at full rate on both sides.
		idling = 1'b0;
		load_codes(StartCodeReset, EscapeCodeReset);
		random_traffic(PHASE_BYTES);
		settle();

		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/efp_pkg.sv
rtl/core/efp_decode.sv
rtl/core/escaped_frame_parser_unit.sv
tb/sv/escaped_frame_parser_unit_test.sv
